/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, held off during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* hdl/pps_pkg.sv */
package pps_pkg;

    localparam int HALVES           = 2;
    localparam int HALF_SAMPLES     = 16384;
    localparam int HALF_W           = $clog2(HALVES);
    localparam int CNT_W            = $clog2(HALF_SAMPLES + 1);
    localparam int MEM_DEPTH        = HALVES * HALF_SAMPLES;
    localparam int ADDR_W           = $clog2(MEM_DEPTH);
    localparam int OP_W             = 3;
    localparam int SAMPLE_W         = 16;
    localparam int INDEX_W          = 14;
    localparam int LEN_W            = 15;
    localparam int PEAK_W           = 15;
    localparam int BYTES_W          = 32;
    localparam int BYTES_PER_SAMPLE = 2;
    // Queue depth must stay a power of two so that the pointers wrap on their own
    localparam int QDEPTH           = 2;
    localparam int QPTR_W           = $clog2(QDEPTH);
    localparam int QCNT_W           = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_SEAL  = 3'd1,
        OP_TAKE  = 3'd2,
        OP_MARK  = 3'd3,
        OP_START = 3'd4,
        OP_STOP  = 3'd5,
        OP_RESET = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_FILLING = 2'd1,
        ST_FULL    = 2'd2
    } half_st_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         index;
    } cmd_t;

    // Magnitude of a 16-bit sample; the most negative value maps to the largest positive
    function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] neg;
        begin
            neg = -raw;
            if (raw == {1'b1, {(SAMPLE_W-1){1'b0}}})
                return {PEAK_W{1'b1}};
            else if (raw[SAMPLE_W-1])
                return neg[PEAK_W-1:0];
            else
                return raw[PEAK_W-1:0];
        end
    endfunction

    function automatic logic [HALF_W-1:0] next_half(input logic [HALF_W-1:0] h);
        begin
            if (h == HALF_W'(HALVES - 1))
                return '0;
            else
                return h + 1'b1;
        end
    endfunction

    function automatic logic [ADDR_W-1:0] half_base(input logic [HALF_W-1:0] h);
        begin
            return ADDR_W'(h) * ADDR_W'(HALF_SAMPLES);
        end
    endfunction

endpackage

/* hdl/pps_front.sv */
module pps_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pps_pkg::OP_W-1:0]          op,
    input  logic signed [pps_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [pps_pkg::INDEX_W-1:0]       read_index,
    output logic                              q_valid,
    output pps_pkg::cmd_t                     q_cmd,
    input  logic                              q_pop
);
    import pps_pkg::*;

    cmd_t              fifo_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    cmd_t              cmd_in;

    assign in_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op     = op_t'(op);
        cmd_in.sample = sample_in;
        cmd_in.index  = read_index;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

/* hdl/pps_back.sv */
module pps_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  pps_pkg::cmd_t                       q_cmd,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pps_pkg::SAMPLE_W-1:0] read_sample,
    output logic [pps_pkg::LEN_W-1:0]           length_out,
    output logic                                overrun_flag,
    output logic [pps_pkg::BYTES_W-1:0]         total_bytes,
    output logic [pps_pkg::PEAK_W-1:0]          peak_level,
    output logic                                running_flag
);
    import pps_pkg::*;

    // Buffer state
    half_st_t           status_reg [HALVES];
    half_st_t           status_next [HALVES];
    logic [CNT_W-1:0]   count_reg [HALVES];
    logic [CNT_W-1:0]   count_next [HALVES];
    logic [PEAK_W-1:0]  hpeak_reg [HALVES];
    logic [PEAK_W-1:0]  hpeak_next [HALVES];
    logic [HALF_W-1:0]  fill_reg, fill_next;
    logic [HALF_W-1:0]  drain_reg, drain_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic               overrun_reg, overrun_next;
    logic               capture_reg, capture_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic               rd_hit_reg, rd_hit_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PEAK_W-1:0]  peak_reg, peak_next;

    // Sample store
    logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       mem_we, mem_re;
    logic [ADDR_W-1:0]          mem_addr;

    logic               exec;
    logic [HALF_W-1:0]  wk_h;
    half_st_t           wk_st;
    logic [CNT_W-1:0]   wk_cnt;
    logic [PEAK_W-1:0]  wk_pk;
    logic [PEAK_W-1:0]  mag;

    assign exec  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = exec;
    assign mag   = magnitude(q_cmd.sample);

    always_comb
    begin
        status_next    = status_reg;
        count_next     = count_reg;
        hpeak_next     = hpeak_reg;
        fill_next      = fill_reg;
        drain_next     = drain_reg;
        bytes_next     = bytes_reg;
        overrun_next   = overrun_reg;
        capture_next   = capture_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = '0;
        rd_hit_next    = 1'b0;
        len_next       = '0;
        wk_h           = fill_reg;
        wk_st          = status_reg[fill_reg];
        wk_cnt         = count_reg[fill_reg];
        wk_pk          = hpeak_reg[fill_reg];

        if (exec)
        begin
            case (q_cmd.op)
                OP_PUSH:
                begin
                    if (capture_reg)
                    begin
                        // Overrun: take over the full half as the drain half and refill it
                        if (wk_st == ST_FULL)
                        begin
                            overrun_next = 1'b1;
                            drain_next   = wk_h;
                            wk_st        = ST_EMPTY;
                        end
                        if (wk_st == ST_EMPTY)
                        begin
                            wk_st  = ST_FILLING;
                            wk_cnt = '0;
                            wk_pk  = '0;
                        end
                        if (wk_cnt < CNT_W'(HALF_SAMPLES))
                        begin
                            mem_we   = 1'b1;
                            mem_addr = half_base(wk_h) + ADDR_W'(wk_cnt);
                            wk_cnt   = wk_cnt + 1'b1;
                            if (mag > wk_pk)
                                wk_pk = mag;
                            if (bytes_reg > ({BYTES_W{1'b1}} - BYTES_W'(BYTES_PER_SAMPLE)))
                                bytes_next = {BYTES_W{1'b1}};
                            else
                                bytes_next = bytes_reg + BYTES_W'(BYTES_PER_SAMPLE);
                        end
                        if (wk_cnt >= CNT_W'(HALF_SAMPLES))
                        begin
                            wk_st     = ST_FULL;
                            fill_next = next_half(wk_h);
                        end
                        status_next[wk_h] = wk_st;
                        count_next[wk_h]  = wk_cnt;
                        hpeak_next[wk_h]  = wk_pk;
                    end
                end
                OP_SEAL:
                begin
                    if ((wk_st == ST_FILLING) && (wk_cnt != '0))
                    begin
                        status_next[wk_h] = ST_FULL;
                        len_next          = LEN_W'(wk_cnt);
                    end
                end
                OP_TAKE:
                begin
                    if (status_reg[drain_reg] == ST_FULL)
                    begin
                        len_next = LEN_W'(count_reg[drain_reg]);
                        if ((32'(q_cmd.index) < 32'(count_reg[drain_reg]))
                            && (32'(q_cmd.index) < 32'(HALF_SAMPLES)))
                        begin
                            rd_hit_next = 1'b1;
                            mem_re      = 1'b1;
                            mem_addr    = half_base(drain_reg) + ADDR_W'(q_cmd.index);
                        end
                    end
                end
                OP_MARK:
                begin
                    status_next[drain_reg] = ST_EMPTY;
                    count_next[drain_reg]  = '0;
                    hpeak_next[drain_reg]  = '0;
                    drain_next             = next_half(drain_reg);
                end
                OP_START, OP_RESET:
                begin
                    for (int i = 0; i < HALVES; i++)
                    begin
                        status_next[i] = ST_EMPTY;
                        count_next[i]  = '0;
                        hpeak_next[i]  = '0;
                    end
                    fill_next    = '0;
                    drain_next   = '0;
                    bytes_next   = '0;
                    overrun_next = 1'b0;
                    capture_next = (q_cmd.op == OP_START);
                end
                OP_STOP:
                begin
                    capture_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        peak_next = '0;
        for (int i = 0; i < HALVES; i++)
        begin
            if (hpeak_next[i] > peak_next)
                peak_next = hpeak_next[i];
        end

        if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HALVES; i++)
            begin
                status_reg[i] <= ST_EMPTY;
                count_reg[i]  <= '0;
                hpeak_reg[i]  <= '0;
            end
            fill_reg      <= '0;
            drain_reg     <= '0;
            bytes_reg     <= '0;
            overrun_reg   <= 1'b0;
            capture_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            count_reg     <= count_next;
            hpeak_reg     <= hpeak_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            bytes_reg     <= bytes_next;
            overrun_reg   <= overrun_next;
            capture_reg   <= capture_next;
            out_valid_reg <= out_valid_next;
            if (exec)
                rd_hit_reg <= rd_hit_next;
        end
    end

    // Snapshot of the state after the item; held while the result waits
    logic               ovr_out_reg, run_out_reg;
    logic [BYTES_W-1:0] bytes_out_reg;

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            len_reg       <= len_next;
            peak_reg      <= peak_next;
            ovr_out_reg   <= overrun_next;
            run_out_reg   <= capture_next;
            bytes_out_reg <= bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= q_cmd.sample;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    assign out_valid    = out_valid_reg;
    assign read_sample  = rd_hit_reg ? rd_data_reg : '0;
    assign length_out   = len_reg;
    assign overrun_flag = ovr_out_reg;
    assign total_bytes  = bytes_out_reg;
    assign peak_level   = peak_reg;
    assign running_flag = run_out_reg;

endmodule

/* hdl/ping_pong_sample_buffer_unit.sv */
// An accepted item is queued, then executed; a result not yet taken by out_ready stalls execution.
// Throughput: one item per cycle if not stalled; the store has one port, used at most once per item.
// A two-entry queue sits in front of the execute stage, one result register behind it.
// Reset (rst_n low, asynchronous): all halves empty, pointers, byte total, overrun and
// capture cleared; sample store contents are left as they are and need no clearing pass.
`include "assert_macros.svh"

module ping_pong_sample_buffer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pps_pkg::OP_W-1:0]            op,
    input  logic signed [pps_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [pps_pkg::INDEX_W-1:0]         read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pps_pkg::SAMPLE_W-1:0] read_sample,
    output logic [pps_pkg::LEN_W-1:0]           length_out,
    output logic                                overrun_flag,
    output logic [pps_pkg::BYTES_W-1:0]         total_bytes,
    output logic [pps_pkg::PEAK_W-1:0]          peak_level,
    output logic                                running_flag
);
    import pps_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    pps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .sample_in  (sample_in),
        .read_index (read_index),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    pps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_sample  (read_sample),
        .length_out   (length_out),
        .overrun_flag (overrun_flag),
        .total_bytes  (total_bytes),
        .peak_level   (peak_level),
        .running_flag (running_flag)
    );

    `ASSERT_IMP(a_pop_needs_item, clk, rst_n, q_pop, q_valid)
    `ASSERT_NXT(a_accept_queued, clk, rst_n, in_valid && in_ready, q_valid)
    `ASSERT_IMP(a_len_bounded, clk, rst_n, out_valid, 32'(length_out) <= 32'(HALF_SAMPLES))
    `ASSERT_IMP(a_sample_has_len, clk, rst_n, out_valid && (read_sample != '0), length_out != '0)

endmodule
